// ===== hw/rtl/brs_pkg.sv =====
package brs_pkg;

  localparam int DEPTH      = 128;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int KEY_W      = 48;
  localparam int CAP_W      = 8;
  localparam int OLD_SLOT_W = 7;
  localparam int FILL_OUT_W = 8;
  localparam int CMP_W      = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);
  localparam int               CAP_MIN   = 2;

  typedef struct packed {
    logic             list_select;
    logic [KEY_W-1:0] key;
  } brs_in_t;

  typedef struct packed {
    logic                  was_present;
    logic [OLD_SLOT_W-1:0] old_slot;
    logic                  evicted;
    logic [KEY_W-1:0]      evicted_key;
    logic [FILL_OUT_W-1:0] fill_after;
  } brs_out_t;

  typedef struct packed {
    logic sel;        // list the beat works on
    logic cmp_en;     // capture the match flag this cycle
    logic live;       // slot lies below the fill count
    logic take_next;  // shift down: load the neighbor above
    logic take_key;   // load the incoming key
  } brs_cell_ctl_t;

endpackage

// ===== hw/rtl/brs_cell.sv =====
module brs_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brs_pkg::brs_cell_ctl_t     ctl,
  input  logic [brs_pkg::KEY_W-1:0]  key,
  input  logic [brs_pkg::KEY_W-1:0]  nxt_recent,
  input  logic [brs_pkg::KEY_W-1:0]  nxt_fresh,
  output logic [brs_pkg::KEY_W-1:0]  recent,
  output logic [brs_pkg::KEY_W-1:0]  fresh,
  output logic                       match
);
  import brs_pkg::*;

  logic [KEY_W-1:0] recent_r;
  logic [KEY_W-1:0] fresh_r;
  logic             match_r;
  logic [KEY_W-1:0] cur;

  assign cur = ctl.sel ? fresh_r : recent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      match_r <= ctl.live && (cur == key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_key) begin
      if (ctl.sel) begin
        fresh_r <= key;
      end else begin
        recent_r <= key;
      end
    end else if (ctl.take_next) begin
      if (ctl.sel) begin
        fresh_r <= nxt_fresh;
      end else begin
        recent_r <= nxt_recent;
      end
    end
  end

  assign recent = recent_r;
  assign fresh  = fresh_r;
  assign match  = match_r;

endmodule

// ===== hw/rtl/bounded_recency_stack.sv =====
// Two move-to-front recency lists of 48-bit keys held in a row of DEPTH
// cells; each cell keeps one slot of both lists, compares it with the key
// and shifts it toward slot 0 when an entry below leaves. Each input beat
// passes through accept, a compare cycle in which every live cell registers
// its match, and an update cycle in which the cells shift, the key lands on
// top and the result goes into the output register. in_ready is high only
// between items, so a new item waits until the last one is done; the update
// cycle waits while an earlier result still sits unclaimed in the output
// register. Capacity is clamped to 2..DEPTH and should be written only while
// both lists are empty. Reset empties both lists.
module bounded_recency_stack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  brs_pkg::brs_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output brs_pkg::brs_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brs_pkg::CAP_W-1:0] cfg_data
);
  import brs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              sel_r;
  logic [KEY_W-1:0]  key_r;
  logic [FILL_W-1:0] fill_recent_r;
  logic [FILL_W-1:0] fill_fresh_r;
  logic [FILL_W-1:0] cur_fill_r;
  logic              full_r;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r;
  brs_out_t          out_data_r;

  logic [CMP_W-1:0]  cap_eff;
  logic [FILL_W-1:0] fill_sel;
  logic              do_upd;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] start;
  logic              shift;
  logic [FILL_W-1:0] fill_new;
  logic [KEY_W-1:0]  oldest;

  logic [DEPTH-1:0]  match;
  logic [KEY_W-1:0]  recent_q [DEPTH];
  logic [KEY_W-1:0]  fresh_q  [DEPTH];

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (CMP_W'(cap_r) < CMP_W'(CAP_MIN)) begin
      cap_eff = CMP_W'(CAP_MIN);
    end else if (CMP_W'(cap_r) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  assign fill_sel = sel_r ? fill_fresh_r : fill_recent_r;
  assign do_upd   = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  // Keys in a list are unique, so the match slot is an OR of cell indexes.
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | match[i];
      slot  = slot | (match[i] ? SLOT_W'(i) : '0);
    end
  end

  assign shift    = found || full_r;
  assign start    = found ? slot : '0;
  assign fill_new = shift ? cur_fill_r : cur_fill_r + FILL_W'(1);
  assign oldest   = sel_r ? fresh_q[0] : recent_q[0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    brs_cell_ctl_t    ctl;
    logic [KEY_W-1:0] up_recent;
    logic [KEY_W-1:0] up_fresh;

    if (g == DEPTH - 1) begin : g_top
      assign up_recent = '0;
      assign up_fresh  = '0;
    end else begin : g_mid
      assign up_recent = recent_q[g+1];
      assign up_fresh  = fresh_q[g+1];
    end

    always_comb begin
      ctl.sel       = sel_r;
      ctl.cmp_en    = (state_r == ST_CMP);
      ctl.live      = FILL_W'(g) < fill_sel;
      ctl.take_next = do_upd && shift && (SLOT_W'(g) >= start)
                      && (FILL_W'(g + 1) < cur_fill_r);
      ctl.take_key  = do_upd && ((shift && (FILL_W'(g + 1) == cur_fill_r))
                      || (!shift && (FILL_W'(g) == cur_fill_r)));
    end

    brs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (key_r),
      .nxt_recent (up_recent),
      .nxt_fresh  (up_fresh),
      .recent     (recent_q[g]),
      .fresh      (fresh_q[g]),
      .match      (match[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (do_upd) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fill_recent_r <= '0;
      fill_fresh_r  <= '0;
      cap_r         <= CAP_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (do_upd) begin
        out_valid_r <= 1'b1;
        if (sel_r) begin
          fill_fresh_r <= fill_new;
        end else begin
          fill_recent_r <= fill_new;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sel_r <= in_data.list_select;
      key_r <= in_data.key;
    end
    if (state_r == ST_CMP) begin
      cur_fill_r <= fill_sel;
      full_r     <= CMP_W'(fill_sel) >= cap_eff;
    end
    if (do_upd) begin
      out_data_r.was_present <= found;
      out_data_r.old_slot    <= OLD_SLOT_W'(slot);
      out_data_r.evicted     <= !found && full_r;
      out_data_r.evicted_key <= (!found && full_r) ? oldest : '0;
      out_data_r.fill_after  <= FILL_OUT_W'(fill_new);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_recent_r <= FILL_W'(DEPTH)) && (fill_fresh_r <= FILL_W'(DEPTH)))
    else $error("fill count beyond depth");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(match))
    else $error("key held in more than one slot");

  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_UPD))
    else $error("result raised outside update");

  a_other_list_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (do_upd && !sel_r) |=> $stable(fill_fresh_r))
    else $error("unselected list changed");

endmodule
